[hw/rtl/jssp_pkg.sv]
// jssp_pkg: shared types and codes for the scan stream parser
// holds the request and response word structs, result kinds and error codes
// no dependencies
package jssp_pkg;

   // request word: one stream byte and the start-of-header flag
   typedef struct packed {
      logic [7:0] data_byte;
      logic       first_byte;
   } req_type;

   // response word: one parser result
   typedef struct packed {
      logic [2:0] kind;
      logic [1:0] comp_index;
      logic [7:0] comp_id;
      logic [1:0] dc_table;
      logic [1:0] ac_table;
      logic [7:0] component_count;
      logic [7:0] spectral_start;
      logic [7:0] spectral_end;
      logic [3:0] approx_high;
      logic [3:0] approx_low;
      logic [7:0] value;
      logic [1:0] error_code;
   } rsp_type;

   // result kinds
   localparam logic [2:0] KIND_COMPONENT = 3'd0;
   localparam logic [2:0] KIND_SCAN      = 3'd1;
   localparam logic [2:0] KIND_DATA      = 3'd2;
   localparam logic [2:0] KIND_RESTART   = 3'd3;
   localparam logic [2:0] KIND_END       = 3'd4;
   localparam logic [2:0] KIND_ERROR     = 3'd5;

   // error codes
   localparam logic [1:0] ERR_DC_TABLE   = 2'd0;
   localparam logic [1:0] ERR_AC_TABLE   = 2'd1;
   localparam logic [1:0] ERR_LENGTH     = 2'd2;
   localparam logic [1:0] ERR_COMPONENTS = 2'd3;

   // marker bytes
   localparam logic [7:0] MARKER_PREFIX  = 8'hff;
   localparam logic [7:0] STUFF_BYTE     = 8'h00;
   localparam logic [7:0] RST_FIRST      = 8'hd0;
   localparam logic [7:0] RST_LAST       = 8'hd7;

   // highest legal entropy table number
   localparam logic [3:0] MAX_TABLE      = 4'd3;

endpackage

[hw/rtl/jpeg_scan_stream_parser_unit.sv]
// jpeg_scan_stream_parser_unit: start-of-scan header and entropy segment parser
// depends on jssp_pkg for the word types, result kinds and error codes
//
// Usage:
//   req channel (req_valid/req_ready/req_payload) carries the bytes that follow
//   an FF DA marker, one byte per word; first_byte marks the high length byte
//   and restarts parsing at any time.
//   rsp channel (rsp_valid/rsp_ready/rsp_payload) carries at most one result
//   word per byte: component entries, scan parameters, data bytes with
//   stuffing removed, restart markers, the closing marker, or an error.
// Timing:
//   an accepted byte waits in the input register; its result is loaded
//   into the output register as the byte leaves, which a held result
//   can delay. One byte per cycle is sustained while results are taken;
//   the state update of one byte in the single parse stage sets that rate.
// Stall:
//   while rsp_ready is low, the input register still takes one more byte and
//   bytes that give no result keep draining; req_ready drops only when a
//   byte with a result waits behind a held result.
// Reset:
//   synchronous, active high; both registers empty, parser idle until a byte
//   with first_byte set arrives. No memories, no clearing pass.
module jpeg_scan_stream_parser_unit #(
   parameter int MAX_COMPONENTS = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  jssp_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output jssp_pkg::rsp_type rsp_payload
);

   localparam int CNT_W = $clog2(MAX_COMPONENTS + 1);
   localparam int HDR_W = $clog2(2 * MAX_COMPONENTS + 7);

   typedef enum logic [3:0] {
      PH_IDLE,
      PH_LEN_LO,
      PH_NS,
      PH_CID,
      PH_CTBL,
      PH_SS,
      PH_SE,
      PH_AHAL,
      PH_BODY
   } phase_type;

   // registers
   logic              in_valid_ff, in_valid_in;
   jssp_pkg::req_type in_word_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   jssp_pkg::rsp_type rsp_word_ff;
   phase_type         phase_ff, phase_in;
   logic [15:0]       seg_len_ff, seg_len_in;
   logic [HDR_W-1:0]  hdr_cnt_ff, hdr_cnt_in;
   logic [CNT_W-1:0]  comp_total_ff, comp_total_in;
   logic [CNT_W-1:0]  comp_cnt_ff, comp_cnt_in;
   logic [7:0]        held_id_ff, held_id_in;
   logic [7:0]        ss_ff, ss_in;
   logic [7:0]        se_ff, se_in;
   logic              pend_ff, pend_in;

   // parse stage signals
   logic              has_res;
   jssp_pkg::rsp_type res;
   logic              can_adv;
   logic              adv;
   logic [7:0]        b;
   logic [3:0]        hi_nib;
   logic [3:0]        lo_nib;
   logic [HDR_W-1:0]  hdr_inc;
   logic [CNT_W-1:0]  cnt_inc;

   assign b       = in_word_ff.data_byte;
   assign hi_nib  = b[7:4];
   assign lo_nib  = b[3:0];
   assign hdr_inc = hdr_cnt_ff + HDR_W'(1);
   assign cnt_inc = comp_cnt_ff + CNT_W'(1);

   // handshake between the two registers
   assign can_adv   = !has_res || !rsp_valid_ff || rsp_ready;
   assign adv       = in_valid_ff && can_adv;
   assign req_ready = !in_valid_ff || adv;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_word_ff;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (adv) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (adv && has_res) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // parse one byte against the current state
   always_comb begin
      res           = '0;
      has_res       = 1'b0;
      phase_in      = phase_ff;
      seg_len_in    = seg_len_ff;
      hdr_cnt_in    = hdr_cnt_ff;
      comp_total_in = comp_total_ff;
      comp_cnt_in   = comp_cnt_ff;
      held_id_in    = held_id_ff;
      ss_in         = ss_ff;
      se_in         = se_ff;
      pend_in       = pend_ff;
      if (in_word_ff.first_byte) begin
         // new header, drop whatever was in progress
         seg_len_in    = {b, 8'h00};
         hdr_cnt_in    = HDR_W'(1);
         comp_total_in = '0;
         comp_cnt_in   = '0;
         held_id_in    = '0;
         pend_in       = 1'b0;
         phase_in      = PH_LEN_LO;
      end else begin
         unique case (phase_ff)
            PH_LEN_LO: begin
               seg_len_in = seg_len_ff | {8'h00, b};
               hdr_cnt_in = HDR_W'(2);
               phase_in   = PH_NS;
            end
            PH_NS: begin
               hdr_cnt_in    = hdr_inc;
               comp_total_in = b[CNT_W-1:0];
               comp_cnt_in   = '0;
               if (b > 8'(MAX_COMPONENTS)) begin
                  has_res        = 1'b1;
                  res.kind       = jssp_pkg::KIND_ERROR;
                  res.error_code = jssp_pkg::ERR_COMPONENTS;
                  phase_in       = PH_IDLE;
                  pend_in        = 1'b0;
               end else if (b == 8'h00) begin
                  phase_in = PH_SS;
               end else begin
                  phase_in = PH_CID;
               end
            end
            PH_CID: begin
               hdr_cnt_in = hdr_inc;
               held_id_in = b;
               phase_in   = PH_CTBL;
            end
            PH_CTBL: begin
               hdr_cnt_in = hdr_inc;
               has_res    = 1'b1;
               // dc nibble is checked before ac nibble
               if (hi_nib > jssp_pkg::MAX_TABLE) begin
                  res.kind       = jssp_pkg::KIND_ERROR;
                  res.error_code = jssp_pkg::ERR_DC_TABLE;
                  phase_in       = PH_IDLE;
                  pend_in        = 1'b0;
               end else if (lo_nib > jssp_pkg::MAX_TABLE) begin
                  res.kind       = jssp_pkg::KIND_ERROR;
                  res.error_code = jssp_pkg::ERR_AC_TABLE;
                  phase_in       = PH_IDLE;
                  pend_in        = 1'b0;
               end else begin
                  res.kind            = jssp_pkg::KIND_COMPONENT;
                  res.comp_index      = 2'(comp_cnt_ff);
                  res.comp_id         = held_id_ff;
                  res.dc_table        = hi_nib[1:0];
                  res.ac_table        = lo_nib[1:0];
                  res.component_count = 8'(comp_total_ff);
                  comp_cnt_in         = cnt_inc;
                  phase_in = (cnt_inc >= comp_total_ff) ? PH_SS : PH_CID;
               end
            end
            PH_SS: begin
               hdr_cnt_in = hdr_inc;
               ss_in      = b;
               phase_in   = PH_SE;
            end
            PH_SE: begin
               hdr_cnt_in = hdr_inc;
               se_in      = b;
               phase_in   = PH_AHAL;
            end
            PH_AHAL: begin
               hdr_cnt_in = hdr_inc;
               has_res    = 1'b1;
               pend_in    = 1'b0;
               if (16'(hdr_inc) != seg_len_ff) begin
                  res.kind       = jssp_pkg::KIND_ERROR;
                  res.error_code = jssp_pkg::ERR_LENGTH;
                  phase_in       = PH_IDLE;
               end else begin
                  res.kind            = jssp_pkg::KIND_SCAN;
                  res.component_count = 8'(comp_total_ff);
                  res.spectral_start  = ss_ff;
                  res.spectral_end    = se_ff;
                  res.approx_high     = hi_nib;
                  res.approx_low      = lo_nib;
                  phase_in            = PH_BODY;
               end
            end
            PH_BODY: begin
               // entropy data: unstuff and pick out markers
               if (!pend_ff) begin
                  if (b == jssp_pkg::MARKER_PREFIX) begin
                     pend_in = 1'b1;
                  end else begin
                     has_res   = 1'b1;
                     res.kind  = jssp_pkg::KIND_DATA;
                     res.value = b;
                  end
               end else begin
                  pend_in = 1'b0;
                  has_res = 1'b1;
                  if (b == jssp_pkg::STUFF_BYTE) begin
                     res.kind  = jssp_pkg::KIND_DATA;
                     res.value = jssp_pkg::MARKER_PREFIX;
                  end else if (b >= jssp_pkg::RST_FIRST && b <= jssp_pkg::RST_LAST) begin
                     res.kind  = jssp_pkg::KIND_RESTART;
                     res.value = {5'b00000, b[2:0]};
                  end else begin
                     res.kind  = jssp_pkg::KIND_END;
                     res.value = b;
                     phase_in  = PH_IDLE;
                  end
               end
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_valid && req_ready) begin
         in_word_ff <= req_payload;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (adv && has_res) begin
         rsp_word_ff <= res;
      end
   end

   // parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         seg_len_ff    <= '0;
         hdr_cnt_ff    <= '0;
         comp_total_ff <= '0;
         comp_cnt_ff   <= '0;
         held_id_ff    <= '0;
         ss_ff         <= '0;
         se_ff         <= '0;
         pend_ff       <= 1'b0;
      end else if (adv) begin
         phase_ff      <= phase_in;
         seg_len_ff    <= seg_len_in;
         hdr_cnt_ff    <= hdr_cnt_in;
         comp_total_ff <= comp_total_in;
         comp_cnt_ff   <= comp_cnt_in;
         held_id_ff    <= held_id_in;
         ss_ff         <= ss_in;
         se_ff         <= se_in;
         pend_ff       <= pend_in;
      end
   end

`ifndef SYNTHESIS
   // a pending marker prefix only exists inside entropy data
   a_pend_in_body: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> phase_ff == PH_BODY)
      else $error("marker prefix pending outside entropy data");

   // an error always leaves the parser idle
   a_error_idle: assert property (@(posedge clock) disable iff (reset)
      (adv && has_res && res.kind == jssp_pkg::KIND_ERROR) |=> phase_ff == PH_IDLE)
      else $error("parser not idle after error");

   // restart words carry only the marker index
   a_restart_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_word_ff.kind == jssp_pkg::KIND_RESTART)
         |-> rsp_word_ff.value[7:3] == 5'b00000)
      else $error("restart index out of range");

   // component positions stay below the configured limit
   a_comp_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_word_ff.kind == jssp_pkg::KIND_COMPONENT)
         |-> 32'(rsp_word_ff.comp_index) < MAX_COMPONENTS)
      else $error("component index beyond limit");
`endif

endmodule

[tb/sv/jpeg_scan_stream_parser_unit_test.sv]
// jpeg_scan_stream_parser_unit_test: self-checking bench for the scan stream parser
// feeds start-of-scan byte streams, predicts every result word and checks them in order
// depends on jssp_pkg and jpeg_scan_stream_parser_unit
module jpeg_scan_stream_parser_unit_test;

   localparam int MAX_COMPONENTS = 4;
   localparam int ITEMS          = 1800;
   localparam int HOLD_CYCLES    = 400;

   // parser model plus the queue of result words still owed by the block
   class scan_result_board;
      typedef enum logic [3:0] {
         PH_IDLE, PH_LEN_LO, PH_COUNT, PH_COMP_ID, PH_COMP_TABLE,
         PH_SPEC_START, PH_SPEC_END, PH_APPROX, PH_BODY
      } parse_phase_type;

      int                max_comps;
      parse_phase_type   phase;
      logic [15:0]       seg_len;
      logic [15:0]       hdr_count;
      logic [7:0]        comp_total;
      logic [2:0]        comp_num;
      logic [7:0]        held_id;
      logic [7:0]        spec_start;
      logic [7:0]        spec_end;
      logic              prefix_seen;
      jssp_pkg::rsp_type expected_words[$];
      int                mismatches;
      int                words_checked;
      int                kind_count[6];

      function new(int max_comps_i);
         max_comps   = max_comps_i;
         phase       = PH_IDLE;
         seg_len     = '0;
         hdr_count   = '0;
         comp_total  = '0;
         comp_num    = '0;
         held_id     = '0;
         spec_start  = '0;
         spec_end    = '0;
         prefix_seen = 1'b0;
         mismatches  = 0;
         words_checked = 0;
         foreach (kind_count[k]) kind_count[k] = 0;
      endfunction

      // any error drops the parser back to idle
      function jssp_pkg::rsp_type error_word(logic [1:0] code);
         jssp_pkg::rsp_type w;
         w = '0;
         w.kind       = jssp_pkg::KIND_ERROR;
         w.error_code = code;
         phase        = PH_IDLE;
         prefix_seen  = 1'b0;
         return w;
      endfunction

      // advance the model by one accepted word; returns 0 when the byte is ignored
      function bit note_byte(jssp_pkg::req_type r);
         jssp_pkg::rsp_type w;
         bit                has_word;
         bit                live;
         logic [7:0]        b;
         logic [3:0]        hi;
         logic [3:0]        lo;
         w        = '0;
         has_word = 1'b0;
         live     = 1'b1;
         b        = r.data_byte;
         hi       = b[7:4];
         lo       = b[3:0];
         if (r.first_byte) begin
            seg_len     = {b, 8'h00};
            hdr_count   = 16'd1;
            comp_total  = '0;
            comp_num    = '0;
            held_id     = '0;
            prefix_seen = 1'b0;
            phase       = PH_LEN_LO;
         end else begin
            case (phase)
               PH_LEN_LO: begin
                  seg_len[7:0] = b;
                  hdr_count    = 16'd2;
                  phase        = PH_COUNT;
               end
               PH_COUNT: begin
                  hdr_count++;
                  comp_total = b;
                  comp_num   = '0;
                  if (b > max_comps) begin
                     w        = error_word(jssp_pkg::ERR_COMPONENTS);
                     has_word = 1'b1;
                  end else if (b == 8'd0) begin
                     phase = PH_SPEC_START;
                  end else begin
                     phase = PH_COMP_ID;
                  end
               end
               PH_COMP_ID: begin
                  hdr_count++;
                  held_id = b;
                  phase   = PH_COMP_TABLE;
               end
               PH_COMP_TABLE: begin
                  hdr_count++;
                  has_word = 1'b1;
                  // dc nibble is checked ahead of the ac nibble
                  if (hi > jssp_pkg::MAX_TABLE) begin
                     w = error_word(jssp_pkg::ERR_DC_TABLE);
                  end else if (lo > jssp_pkg::MAX_TABLE) begin
                     w = error_word(jssp_pkg::ERR_AC_TABLE);
                  end else begin
                     w.kind            = jssp_pkg::KIND_COMPONENT;
                     w.comp_index      = comp_num[1:0];
                     w.comp_id         = held_id;
                     w.dc_table        = hi[1:0];
                     w.ac_table        = lo[1:0];
                     w.component_count = comp_total;
                     comp_num          = comp_num + 3'd1;
                     if (comp_num >= comp_total) phase = PH_SPEC_START;
                     else phase = PH_COMP_ID;
                  end
               end
               PH_SPEC_START: begin
                  hdr_count++;
                  spec_start = b;
                  phase      = PH_SPEC_END;
               end
               PH_SPEC_END: begin
                  hdr_count++;
                  spec_end = b;
                  phase    = PH_APPROX;
               end
               PH_APPROX: begin
                  hdr_count++;
                  has_word = 1'b1;
                  if (hdr_count != seg_len) begin
                     w = error_word(jssp_pkg::ERR_LENGTH);
                  end else begin
                     w.kind            = jssp_pkg::KIND_SCAN;
                     w.component_count = comp_total;
                     w.spectral_start  = spec_start;
                     w.spectral_end    = spec_end;
                     w.approx_high     = hi;
                     w.approx_low      = lo;
                     prefix_seen       = 1'b0;
                     phase             = PH_BODY;
                  end
               end
               PH_BODY: begin
                  if (!prefix_seen) begin
                     if (b == jssp_pkg::MARKER_PREFIX) begin
                        prefix_seen = 1'b1;
                     end else begin
                        w.kind   = jssp_pkg::KIND_DATA;
                        w.value  = b;
                        has_word = 1'b1;
                     end
                  end else begin
                     prefix_seen = 1'b0;
                     has_word    = 1'b1;
                     if (b == jssp_pkg::STUFF_BYTE) begin
                        w.kind  = jssp_pkg::KIND_DATA;
                        w.value = jssp_pkg::MARKER_PREFIX;
                     end else if (b >= jssp_pkg::RST_FIRST && b <= jssp_pkg::RST_LAST) begin
                        w.kind  = jssp_pkg::KIND_RESTART;
                        w.value = {5'd0, b[2:0]};
                     end else begin
                        w.kind  = jssp_pkg::KIND_END;
                        w.value = b;
                        phase   = PH_IDLE;
                     end
                  end
               end
               default: begin
                  live  = 1'b0;
                  phase = PH_IDLE;
               end
            endcase
         end
         if (has_word) begin
            expected_words.push_back(w);
            kind_count[w.kind]++;
         end
         return live;
      endfunction

      function void compare_field(string name, logic [7:0] want_v, logic [7:0] got_v);
         if (got_v !== want_v) begin
            mismatches++;
            if (mismatches <= 40)
               $display("%0t: %s mismatch: expected %0h, actual %0h",
                        $time, name, want_v, got_v);
         end
      endfunction

      // compare one accepted result word with the oldest prediction
      function void check_word(jssp_pkg::rsp_type got);
         jssp_pkg::rsp_type want;
         words_checked++;
         if (expected_words.size() == 0) begin
            mismatches++;
            if (mismatches <= 40)
               $display("%0t: unexpected result word: expected none, actual %h",
                        $time, got);
            return;
         end
         want = expected_words.pop_front();
         compare_field("kind", 8'(want.kind), 8'(got.kind));
         compare_field("comp_index", 8'(want.comp_index), 8'(got.comp_index));
         compare_field("comp_id", want.comp_id, got.comp_id);
         compare_field("dc_table", 8'(want.dc_table), 8'(got.dc_table));
         compare_field("ac_table", 8'(want.ac_table), 8'(got.ac_table));
         compare_field("component_count", want.component_count, got.component_count);
         compare_field("spectral_start", want.spectral_start, got.spectral_start);
         compare_field("spectral_end", want.spectral_end, got.spectral_end);
         compare_field("approx_high", 8'(want.approx_high), 8'(got.approx_high));
         compare_field("approx_low", 8'(want.approx_low), 8'(got.approx_low));
         compare_field("value", want.value, got.value);
         compare_field("error_code", 8'(want.error_code), 8'(got.error_code));
      endfunction

      function void report_leftover();
         if (expected_words.size() != 0) begin
            mismatches += expected_words.size();
            $display("%0t: %0d result words never arrived: expected kind %0d first, actual none",
                     $time, expected_words.size(), expected_words[0].kind);
         end
      endfunction
   endclass

   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              req_valid   = 1'b0;
   logic              req_ready;
   jssp_pkg::req_type req_payload = '0;
   logic              rsp_valid;
   logic              rsp_ready   = 1'b0;
   jssp_pkg::rsp_type rsp_payload;

   scan_result_board results = new(MAX_COMPONENTS);

   int bytes_sent  = 0;
   int live_bytes  = 0;
   int burst_left  = 0;
   bit steady      = 1'b0;
   int hold_asks   = 0;
   int hold_seen   = 0;
   int hold_left   = 0;
   int pat_left    = 0;
   int pat_mode    = 0;

   jpeg_scan_stream_parser_unit #(
      .MAX_COMPONENTS(MAX_COMPONENTS)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_payload(rsp_payload)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // receiver: long hold-off on request, otherwise a changing stall pattern
   always @(posedge clock) begin
      if (hold_asks != hold_seen) begin
         hold_seen = hold_asks;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         if (pat_left == 0) begin
            pat_mode = $urandom_range(0, 3);
            pat_left = $urandom_range(20, 200);
         end
         pat_left--;
         case (pat_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= ($urandom_range(0, 3) != 0);
            2: rsp_ready <= 1'($urandom_range(0, 1));
            default: rsp_ready <= ((pat_left % 5) < 2);
         endcase
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) results.check_word(rsp_payload);
   end

   // offer one word, wait for it to be taken, then maybe open a gap between bursts
   task automatic send_byte(input logic [7:0] b, input logic f);
      jssp_pkg::req_type w;
      int                gap;
      w.data_byte  = b;
      w.first_byte = f;
      req_payload <= w;
      req_valid   <= 1'b1;
      do @(posedge clock); while (!req_ready);
      bytes_sent++;
      if (results.note_byte(w)) live_bytes++;
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 30);
         gap = steady ? 0 : $urandom_range(1, 10);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // sender goes quiet until every predicted word has come back
   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (results.expected_words.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic run_directed();
      send_byte(8'h5a, 1'b0);
      // no components, length 6, extreme spectral bytes
      send_byte(8'h00, 1'b1); send_byte(8'h06, 1'b0); send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b0); send_byte(8'hff, 1'b0); send_byte(8'hf0, 1'b0);
      // plain byte, stuffed ff, both restart extremes, then a lone prefix
      send_byte(8'h00, 1'b0); send_byte(8'hff, 1'b0); send_byte(8'h00, 1'b0);
      send_byte(8'hff, 1'b0); send_byte(8'hd0, 1'b0);
      send_byte(8'hff, 1'b0); send_byte(8'hd7, 1'b0);
      send_byte(8'hff, 1'b0);
      // new header over the pending prefix, component count above the limit
      send_byte(8'h00, 1'b1); send_byte(8'h06, 1'b0); send_byte(8'h05, 1'b0);
      // both nibbles bad: dc wins
      send_byte(8'h00, 1'b1); send_byte(8'h08, 1'b0); send_byte(8'h01, 1'b0);
      send_byte(8'hff, 1'b0); send_byte(8'h44, 1'b0);
      // bad ac nibble
      send_byte(8'h00, 1'b1); send_byte(8'h08, 1'b0); send_byte(8'h01, 1'b0);
      send_byte(8'h00, 1'b0); send_byte(8'h3f, 1'b0);
      // length that cannot match
      send_byte(8'hff, 1'b1); send_byte(8'hff, 1'b0); send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b0); send_byte(8'h3f, 1'b0); send_byte(8'h0f, 1'b0);
      // one component, then an ff ff end marker and a byte that is ignored
      send_byte(8'h00, 1'b1); send_byte(8'h08, 1'b0); send_byte(8'h01, 1'b0);
      send_byte(8'h01, 1'b0); send_byte(8'h33, 1'b0);
      send_byte(8'h00, 1'b0); send_byte(8'h3f, 1'b0); send_byte(8'h0f, 1'b0);
      send_byte(8'hfe, 1'b0); send_byte(8'hff, 1'b0); send_byte(8'hff, 1'b0);
      send_byte(8'h00, 1'b0);
   endtask

   // one scan: header, entropy data and usually a closing marker
   task automatic send_scan(input int body_len);
      logic [8:0]  stream[$];
      int          count;
      int          pick;
      int          i;
      logic [15:0] len;
      logic [7:0]  e;
      pick  = $urandom_range(0, 99);
      count = (pick < 6) ? $urandom_range(MAX_COMPONENTS + 1, 255)
                         : $urandom_range(0, MAX_COMPONENTS);
      len = 16'(6 + 2 * count);
      if ($urandom_range(0, 99) < 8) len = 16'($urandom_range(0, 65535));
      stream.push_back({len[15:8], 1'b1});
      stream.push_back({len[7:0], 1'b0});
      stream.push_back({8'(count), 1'b0});
      if (count <= MAX_COMPONENTS) begin
         for (i = 0; i < count; i++) begin
            stream.push_back({8'($urandom), 1'b0});
            if ($urandom_range(0, 99) < 5)
               stream.push_back({8'($urandom), 1'b0});
            else
               stream.push_back({2'b00, 2'($urandom), 2'b00, 2'($urandom), 1'b0});
         end
         for (i = 0; i < 3; i++) stream.push_back({8'($urandom), 1'b0});
         // entropy data with stuffing and restarts mixed in
         for (i = 0; i < body_len; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
               stream.push_back({8'($urandom_range(0, 254)), 1'b0});
            end else if (pick < 80) begin
               stream.push_back({jssp_pkg::MARKER_PREFIX, 1'b0});
               stream.push_back({jssp_pkg::STUFF_BYTE, 1'b0});
            end else if (pick < 90) begin
               stream.push_back({jssp_pkg::MARKER_PREFIX, 1'b0});
               stream.push_back({5'b11010, 3'($urandom), 1'b0});
            end else begin
               stream.push_back({8'($urandom), 1'b0});
            end
         end
         pick = $urandom_range(0, 99);
         if (pick < 80) begin
            do e = 8'($urandom);
            while (e == jssp_pkg::STUFF_BYTE ||
                   (e >= jssp_pkg::RST_FIRST && e <= jssp_pkg::RST_LAST));
            if ($urandom_range(0, 99) < 15) e = jssp_pkg::MARKER_PREFIX;
            stream.push_back({jssp_pkg::MARKER_PREFIX, 1'b0});
            stream.push_back({e, 1'b0});
         end else if (pick < 90) begin
            stream.push_back({jssp_pkg::MARKER_PREFIX, 1'b0});
         end
      end
      // now and then the next first flag cuts the scan short
      if ($urandom_range(0, 99) < 4)
         stream = stream[0:$urandom_range(0, stream.size() - 1)];
      for (i = $urandom_range(0, 2); i > 0; i--) stream.push_back({8'($urandom), 1'b0});
      foreach (stream[j]) send_byte(stream[j][8:1], stream[j][0]);
   endtask

   // loose bytes with the first flag set at random
   task automatic send_noise();
      int n;
      for (n = $urandom_range(1, 6); n > 0; n--)
         send_byte(8'($urandom), ($urandom_range(0, 4) == 0));
   endtask

   initial begin
      int scan_no;
      scan_no = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      run_directed();
      wait_for_results();
      while (bytes_sent < ITEMS) begin
         steady = ($urandom_range(0, 4) == 0);
         if (scan_no == 6 || scan_no == 60) begin
            // long receiver hold-off while a long scan keeps coming
            hold_asks <= hold_asks + 1;
            send_scan(120);
         end else if ($urandom_range(0, 9) == 0) begin
            send_noise();
         end else begin
            send_scan($urandom_range(0, 24));
         end
         if (scan_no % 25 == 24) wait_for_results();
         scan_no++;
      end
      wait_for_results();
      repeat (20) @(posedge clock);
      results.report_leftover();
      $display("run covered %0d bytes (%0d parsed) in %0d scans, %0d result words, %0d hold-offs",
               bytes_sent, live_bytes, scan_no, results.words_checked, hold_seen);
      $display("words by kind: comp %0d scan %0d data %0d restart %0d end %0d error %0d",
               results.kind_count[jssp_pkg::KIND_COMPONENT],
               results.kind_count[jssp_pkg::KIND_SCAN],
               results.kind_count[jssp_pkg::KIND_DATA],
               results.kind_count[jssp_pkg::KIND_RESTART],
               results.kind_count[jssp_pkg::KIND_END],
               results.kind_count[jssp_pkg::KIND_ERROR]);
      if (results.mismatches == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   // run limit
   initial begin
      #5000000;
      $display("timeout waiting for the parser");
      $display("FAILED: results differ");
      $finish;
   end

endmodule
